// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a synchronous active-low reset as disable.
`define AST_SYNC(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, written as an overlapping implication.
`define AST_IMPLY(lbl, clk, rstn, pre, post, msg) \
    `AST_SYNC(lbl, clk, rstn, (pre) |-> (post), msg)

`endif

// ===== hdl/ghe_pkg.sv =====
package ghe_pkg;

    localparam int NUM_BINS   = 256;
    localparam int COUNT_BITS = 25;
    localparam int BIN_BITS   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    localparam int REQ_W      = 2;
    localparam int LEVEL_W    = 8;
    localparam int OUT_W      = 8;
    localparam int REG_BITS   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 2 * REG_BITS;
    localparam int NUM_W      = COUNT_BITS + OUT_W;
    localparam int DIV_W      = (NUM_W > PIX_W + OUT_W) ? NUM_W : PIX_W + OUT_W;
    localparam int STEP_W     = $clog2(OUT_W);

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COUNT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MAP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};
    localparam logic [OUT_W-1:0]      LEVEL_MAX   = {OUT_W{1'b1}};
    localparam logic [REG_BITS-1:0]   REG_RESET   = REG_BITS'(1);

    typedef struct packed {
        logic                  clr;
        logic                  rd_en;
        logic [BIN_BITS-1:0]   rd_addr;
        logic                  wr_en;
        logic [BIN_BITS-1:0]   wr_addr;
        logic [COUNT_BITS-1:0] wr_data;
    } t_ram_req;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [PIX_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== hdl/ghe_if.sv =====
interface ghe_pix_if;
    logic                        valid;
    logic                        ready;
    logic [ghe_pkg::REQ_W-1:0]   req_type;
    logic [ghe_pkg::LEVEL_W-1:0] pixel_value;

    modport source (output valid, output req_type, output pixel_value, input ready);
    modport sink   (input valid, input req_type, input pixel_value, output ready);
endinterface

interface ghe_eq_if;
    logic                      valid;
    logic                      ready;
    logic [ghe_pkg::OUT_W-1:0] equalized_value;

    modport source (output valid, output equalized_value, input ready);
    modport sink   (input valid, input equalized_value, output ready);
endinterface

interface ghe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ghe_pkg::CFG_IDX_W-1:0] reg_index;
    logic [ghe_pkg::REG_BITS-1:0]  reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== hdl/ghe_bin_ram.sv =====
module ghe_bin_ram (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ghe_pkg::t_ram_req              i_req,
    output logic [ghe_pkg::COUNT_BITS-1:0] o_rd_data
);

    logic [ghe_pkg::COUNT_BITS-1:0] r_mem [ghe_pkg::NUM_BINS];
    logic [ghe_pkg::NUM_BINS-1:0]   r_vld;
    logic [ghe_pkg::COUNT_BITS-1:0] r_rd_data;
    logic                           r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // entries not written since the last clear read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== hdl/ghe_div.sv =====
module ghe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ghe_pkg::t_div_req i_req,
    output ghe_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [ghe_pkg::STEP_W-1:0]    r_step;
    logic [ghe_pkg::DIV_W-1:0]     r_rem;
    logic [ghe_pkg::DIV_W-1:0]     r_den;
    logic [ghe_pkg::OUT_W-1:0]     r_q;

    logic [ghe_pkg::DIV_W-1:0]     num_ext;
    logic [ghe_pkg::DIV_W-1:0]     den_ext;
    logic [ghe_pkg::DIV_W-1:0]     den_top;
    logic                          ovf;
    logic                          ge;

    assign num_ext = ghe_pkg::DIV_W'(i_req.num);
    assign den_ext = ghe_pkg::DIV_W'(i_req.den);
    assign den_top = den_ext << ghe_pkg::OUT_W;
    // quotient would not fit, or no pixels: clamp
    assign ovf     = (i_req.den == '0) || (num_ext >= den_top);
    assign ge      = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && (r_step == ghe_pkg::STEP_W'(ghe_pkg::OUT_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_step <= '0;
            r_rem  <= num_ext;
            r_den  <= den_ext << (ghe_pkg::OUT_W - 1);
            r_q    <= ovf ? ghe_pkg::LEVEL_MAX : '0;
        end else if (r_busy) begin
            r_step <= r_step + ghe_pkg::STEP_W'(1);
            r_rem  <= ge ? (r_rem - r_den) : r_rem;
            r_den  <= r_den >> 1;
            r_q    <= {r_q[ghe_pkg::OUT_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ===== hdl/gray_histogram_equalizer.sv =====
// Channel   Dir  Payload                     Handshake
// i_pix     in   req_type, pixel_value       valid / ready
// o_eq      out  equalized_value             valid / ready
// i_cfg     in   reg_index, reg_data         valid / ready (ready out of reset)
//
// Count beats: one per cycle while idle; bin RAM read-modify-write, write forwarding.
// Clear: all bins cleared at once through the RAM valid bits.
// Map: drain, bin read, 8-step serial divide (or clamp), then the output register;
// the first map after a clear adds the running-sum sweep; count beats then do nothing.
// Synchronous active-low reset; all bins read as zero after it.
// A waiting result does not block count beats; a map waits for the output register.
module gray_histogram_equalizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ghe_pix_if.sink   i_pix,
    ghe_eq_if.source  o_eq,
    ghe_cfg_if.sink   i_cfg
);

    `include "assert_macros.svh"

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DRAIN = 7'b0000010,
        S_SUM   = 7'b0000100,
        S_MRD   = 7'b0001000,
        S_MDAT  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [ghe_pkg::REQ_W-1:0]       r_req, n_req;
    logic [ghe_pkg::BIN_BITS-1:0]    r_idx, n_idx;
    logic                            r_cum, n_cum;
    logic                            r_p1_vld, n_p1_vld;
    logic [ghe_pkg::BIN_BITS-1:0]    r_p1_idx, n_p1_idx;
    logic                            r_fw_vld, n_fw_vld;
    logic [ghe_pkg::BIN_BITS-1:0]    r_fw_idx, n_fw_idx;
    logic [ghe_pkg::COUNT_BITS-1:0]  r_fw_data, n_fw_data;
    logic [ghe_pkg::BIN_BITS:0]      r_k, n_k;
    logic [ghe_pkg::COUNT_BITS-1:0]  r_acc, n_acc;
    logic                            r_sum_rd, n_sum_rd;
    logic [ghe_pkg::OUT_W-1:0]       r_res, n_res;
    logic                            r_out_vld, n_out_vld;
    logic [ghe_pkg::OUT_W-1:0]       r_out_data, n_out_data;
    logic [ghe_pkg::REG_BITS-1:0]    r_width;
    logic [ghe_pkg::REG_BITS-1:0]    r_height;
    logic [ghe_pkg::PIX_W-1:0]       r_pixels;

    ghe_pkg::t_ram_req               ram_req;
    ghe_pkg::t_div_req               div_req;
    ghe_pkg::t_div_rsp               div_rsp;
    logic [ghe_pkg::COUNT_BITS-1:0]  rd_data;

    logic                            in_acc;
    logic [ghe_pkg::BIN_BITS-1:0]    pix_idx;
    logic [ghe_pkg::COUNT_BITS-1:0]  cnt_cur;
    logic [ghe_pkg::COUNT_BITS-1:0]  cnt_new;
    logic [ghe_pkg::COUNT_BITS:0]    sum_ext;
    logic [ghe_pkg::COUNT_BITS-1:0]  sum_sat;
    logic [ghe_pkg::BIN_BITS-1:0]    k_prev;

    ghe_bin_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    ghe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_pix.ready        = (r_state == S_IDLE) && i_rst_n;
    assign in_acc             = i_pix.valid && i_pix.ready;
    assign i_cfg.ready        = i_rst_n;
    assign o_eq.valid         = r_out_vld;
    assign o_eq.equalized_value = r_out_data;

    // levels past the last bin fall into it
    assign pix_idx = (32'(i_pix.pixel_value) >= ghe_pkg::NUM_BINS)
                   ? ghe_pkg::BIN_BITS'(ghe_pkg::NUM_BINS - 1)
                   : ghe_pkg::BIN_BITS'(i_pix.pixel_value);

    // write of the previous cycle is not yet seen by the RAM read
    assign cnt_cur = (r_fw_vld && (r_fw_idx == r_p1_idx)) ? r_fw_data : rd_data;
    assign cnt_new = (cnt_cur == ghe_pkg::COUNT_LIMIT) ? cnt_cur
                   : cnt_cur + ghe_pkg::COUNT_BITS'(1);

    assign sum_ext = {1'b0, r_acc} + {1'b0, rd_data};
    assign sum_sat = sum_ext[ghe_pkg::COUNT_BITS] ? ghe_pkg::COUNT_LIMIT
                   : sum_ext[ghe_pkg::COUNT_BITS-1:0];
    assign k_prev  = r_k[ghe_pkg::BIN_BITS-1:0] - ghe_pkg::BIN_BITS'(1);

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_idx      = r_idx;
        n_cum      = r_cum;
        n_p1_vld   = 1'b0;
        n_p1_idx   = r_p1_idx;
        n_fw_vld   = 1'b0;
        n_fw_idx   = r_fw_idx;
        n_fw_data  = r_fw_data;
        n_k        = r_k;
        n_acc      = r_acc;
        n_sum_rd   = 1'b0;
        n_res      = r_res;
        n_out_vld  = r_out_vld && !o_eq.ready;
        n_out_data = r_out_data;
        ram_req    = '0;
        div_req    = '0;

        if (r_p1_vld) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = r_p1_idx;
            ram_req.wr_data = cnt_new;
            n_fw_vld        = 1'b1;
            n_fw_idx        = r_p1_idx;
            n_fw_data       = cnt_new;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_pix.req_type) inside
                        ghe_pkg::REQ_COUNT: begin
                            if (!r_cum) begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = pix_idx;
                                n_p1_vld        = 1'b1;
                                n_p1_idx        = pix_idx;
                            end
                        end
                        ghe_pkg::REQ_CLEAR, ghe_pkg::REQ_MAP: begin
                            n_req   = i_pix.req_type;
                            n_idx   = pix_idx;
                            n_state = S_DRAIN;
                        end
                        default: ;
                    endcase
                end
            end
            S_DRAIN: begin
                if (r_req == ghe_pkg::REQ_CLEAR) begin
                    ram_req.clr = 1'b1;
                    n_cum       = 1'b0;
                    n_state     = S_IDLE;
                end else if (r_cum) begin
                    n_state = S_MRD;
                end else begin
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_sum_rd) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = k_prev;
                    ram_req.wr_data = sum_sat;
                    n_acc           = sum_sat;
                end
                if (r_k < (ghe_pkg::BIN_BITS + 1)'(ghe_pkg::NUM_BINS)) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = r_k[ghe_pkg::BIN_BITS-1:0];
                    n_k             = r_k + (ghe_pkg::BIN_BITS + 1)'(1);
                    n_sum_rd        = 1'b1;
                end else begin
                    n_cum   = 1'b1;
                    n_state = S_MRD;
                end
            end
            S_MRD: begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = r_idx;
                n_state         = S_MDAT;
            end
            S_MDAT: begin
                // x * 255 as x * 256 - x
                div_req.start = 1'b1;
                div_req.num   = ghe_pkg::NUM_W'({rd_data, ghe_pkg::OUT_W'(0)})
                              - ghe_pkg::NUM_W'(rd_data);
                div_req.den   = r_pixels;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res   = div_rsp.quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_vld || o_eq.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = r_res;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cum     <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_sum_rd  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cum     <= n_cum;
            r_p1_vld  <= n_p1_vld;
            r_fw_vld  <= n_fw_vld;
            r_sum_rd  <= n_sum_rd;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_p1_idx   <= n_p1_idx;
        r_fw_idx   <= n_fw_idx;
        r_fw_data  <= n_fw_data;
        r_k        <= n_k;
        r_acc      <= n_acc;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_pixels   <= ghe_pkg::PIX_W'(r_width) * ghe_pkg::PIX_W'(r_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ghe_pkg::REG_RESET;
            r_height <= ghe_pkg::REG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                ghe_pkg::REG_WIDTH:  r_width  <= i_cfg.reg_data;
                ghe_pkg::REG_HEIGHT: r_height <= i_cfg.reg_data;
                default: ;
            endcase
        end
    end

    `AST_IMPLY(a_p1_from_idle, i_clk, i_rst_n, r_p1_vld,
        $past(r_state == S_IDLE && !r_cum), "count write without an idle count beat")
    `AST_IMPLY(a_div_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV,
        "divider result outside divide state")
    `AST_IMPLY(a_map_after_sum, i_clk, i_rst_n, r_state == S_MRD, r_cum,
        "map read before running sum")

endmodule
